>>> hw/rtl/sfh_pkg.sv
// Shared types and constants for the symmetric flow hash sampler.
// Holds the normalized key, the result record and the configuration record.
// No dependencies; every other file of the block but sfh_fifo refers to it by scoped names.
package sfh_pkg;

    // Multiplier of the multiplicative hash.
    localparam logic [31:0] HASH_PRIME = 32'd86477;
    localparam logic [31:0] ALL_ONES   = 32'hffff_ffff;

    // Defaults of the top-level parameters.
    localparam int CODE_BYTES_DEFAULT  = 4;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // Configuration register indexes.
    localparam int          CFG_INDEX_W         = 2;
    localparam logic [1:0]  REG_CRC_POLYNOMIAL  = 2'd0;
    localparam logic [1:0]  REG_SAMPLING_ON     = 2'd1;
    localparam logic [1:0]  REG_SAMPLING_LIMIT  = 2'd2;

    // Flow key with the endpoints already put in canonical order.
    typedef struct packed {
        logic [31:0] addr1;
        logic [31:0] addr2;
        logic [15:0] port1;
        logic [15:0] port2;
        logic        is_ipv4;
        logic [7:0]  network_code;
        logic [7:0]  transport_code;
    } key_t;

    // One result record.
    typedef struct packed {
        logic [31:0] hash_value;
        logic        accepted;
        logic [31:0] accepted_total;
        logic [31:0] dropped_total;
    } result_t;

    // Configuration registers as seen by the hash engine.
    typedef struct packed {
        logic [31:0] crc_polynomial;
        logic        sampling_on;
        logic [31:0] sampling_limit;
    } cfg_t;

endpackage

>>> hw/rtl/sfh_fifo.sv
// Small synchronous FIFO used between the front end, the hash engine and the result port.
// Generic in width and depth; no package dependency.
module sfh_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wdata,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_write;
    logic             do_read;

    assign full     = (count_reg == DEPTH_CNT);
    assign empty    = (count_reg == '0);
    assign do_write = wr_en && !full;
    assign do_read  = rd_en && !empty;
    assign rdata    = mem[rd_ptr_reg];

    // Storage array.
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_write)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_read)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_write && !do_read)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_read && !do_write)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

`ifndef SYNTHESIS
    // The fill count never passes the depth.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= DEPTH_CNT)
        else $error("fifo count exceeds depth");

    // A lone write grows the fill count by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_write && !do_read) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("fifo count did not follow a write");

    // A lone read shrinks the fill count by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_read && !do_write) |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("fifo count did not follow a read");
`endif

endmodule

>>> hw/rtl/sfh_front.sv
// Front end of the flow hash sampler: puts the two endpoints of a key in canonical order.
// Depends on sfh_pkg for the key record.
module sfh_front (
    input  logic [31:0]   source_address,
    input  logic [31:0]   dest_address,
    input  logic [15:0]   source_port,
    input  logic [15:0]   dest_port,
    input  logic          is_ipv4,
    input  logic [7:0]    network_code,
    input  logic [7:0]    transport_code,
    output sfh_pkg::key_t key
);

    logic src_first;

    // The smaller address goes first; on a tie the destination endpoint does.
    assign src_first = (source_address < dest_address);

    always_comb
    begin
        key.addr1          = src_first ? source_address : dest_address;
        key.addr2          = src_first ? dest_address   : source_address;
        key.port1          = src_first ? source_port    : dest_port;
        key.port2          = src_first ? dest_port      : source_port;
        key.is_ipv4        = is_ipv4;
        key.network_code   = network_code;
        key.transport_code = transport_code;
    end

endmodule

>>> hw/rtl/sfh_engine.sv
// Back end of the flow hash sampler: byte-serial CRC or multiply-accumulate hash, sampling
// decision and the accepted and dropped counters. Depends on sfh_pkg.
module sfh_engine #(
    parameter int CODE_BYTES = sfh_pkg::CODE_BYTES_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  sfh_pkg::cfg_t    cfg,
    input  logic             key_valid,
    input  sfh_pkg::key_t    key,
    output logic             key_pop,
    input  logic             res_full,
    output logic             res_push,
    output sfh_pkg::result_t res
);

    localparam logic [1:0] CODE_LAST = 2'(CODE_BYTES - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CRC,
        S_MUL,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        SEG_NET,
        SEG_TRN,
        SEG_P1,
        SEG_P2,
        SEG_A1,
        SEG_A2
    } seg_t;

    state_t        state_reg;
    seg_t          seg_reg;
    logic [1:0]    byte_reg;
    logic [1:0]    step_reg;
    sfh_pkg::key_t key_reg;
    logic [31:0]   hash_reg;
    logic [31:0]   acc_reg;
    logic [31:0]   drop_reg;

    logic [31:0]   seg_val;
    logic [1:0]    seg_last;
    logic [31:0]   crc_step;
    logic [31:0]   crc_next;
    logic          end_of_seg;
    logic          final_seg;
    logic [31:0]   mul_a;
    logic [31:0]   addend;
    logic [31:0]   mac_next;
    logic          drop;
    logic [31:0]   acc_inc;
    logic [31:0]   drop_inc;
    logic [31:0]   acc_next;
    logic [31:0]   drop_next;

    // Eight reflected CRC bit steps over one byte.
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b,
                                             input logic [31:0] poly);
        logic [31:0] w;
        w = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            w = w[0] ? (poly ^ (w >> 1)) : (w >> 1);
        end
        return w;
    endfunction

    // Value and length of the current CRC call.
    always_comb
    begin
        case (seg_reg)
            SEG_NET: seg_val = {24'd0, key_reg.network_code};
            SEG_TRN: seg_val = {24'd0, key_reg.transport_code};
            SEG_P1:  seg_val = {16'd0, key_reg.port1};
            SEG_P2:  seg_val = {16'd0, key_reg.port2};
            SEG_A1:  seg_val = key_reg.addr1;
            SEG_A2:  seg_val = key_reg.addr2;
            default: seg_val = '0;
        endcase
        case (seg_reg)
            SEG_NET, SEG_TRN: seg_last = CODE_LAST;
            SEG_P1, SEG_P2:   seg_last = 2'd1;
            default:          seg_last = 2'd3;
        endcase
    end

    // One CRC byte per cycle; a call closes with an inversion.
    assign crc_step   = crc_byte(hash_reg, seg_val[8*byte_reg +: 8], cfg.crc_polynomial);
    assign end_of_seg = (byte_reg == seg_last);
    assign crc_next   = end_of_seg ? ~crc_step : crc_step;
    assign final_seg  = (seg_reg == SEG_A2) || ((seg_reg == SEG_TRN) && !key_reg.is_ipv4);

    // Multiply-accumulate: x = a1*P + a2, then x*P + p1, x*P + p2, x*P.
    always_comb
    begin
        mul_a = (step_reg == 2'd0) ? key_reg.addr1 : hash_reg;
        case (step_reg)
            2'd0:    addend = key_reg.addr2;
            2'd1:    addend = {16'd0, key_reg.port1};
            2'd2:    addend = {16'd0, key_reg.port2};
            default: addend = '0;
        endcase
        mac_next = 32'(mul_a * sfh_pkg::HASH_PRIME) + addend;
    end

    // Sampling decision and counter update; a wrap of one counter clears the other.
    always_comb
    begin
        drop      = cfg.sampling_on && (hash_reg > cfg.sampling_limit);
        acc_inc   = acc_reg + 32'd1;
        drop_inc  = drop_reg + 32'd1;
        acc_next  = acc_reg;
        drop_next = drop_reg;
        if (cfg.sampling_on)
        begin
            if (drop)
            begin
                drop_next = drop_inc;
                acc_next  = (drop_inc == '0) ? '0 : acc_reg;
            end
            else
            begin
                acc_next  = acc_inc;
                drop_next = (acc_inc == '0) ? '0 : drop_reg;
            end
        end
    end

    assign key_pop  = (state_reg == S_IDLE) && key_valid;
    assign res_push = (state_reg == S_DONE) && !res_full;

    always_comb
    begin
        res.hash_value     = hash_reg;
        res.accepted       = !drop;
        res.accepted_total = acc_next;
        res.dropped_total  = drop_next;
    end

    // Sequencer, key and hash registers, counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            seg_reg   <= SEG_NET;
            byte_reg  <= '0;
            step_reg  <= '0;
            key_reg   <= '0;
            hash_reg  <= '0;
            acc_reg   <= '0;
            drop_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (key_valid)
                    begin
                        key_reg  <= key;
                        seg_reg  <= SEG_NET;
                        byte_reg <= '0;
                        step_reg <= '0;
                        if (cfg.crc_polynomial != '0)
                        begin
                            hash_reg  <= sfh_pkg::ALL_ONES;
                            state_reg <= S_CRC;
                        end
                        else if (key.is_ipv4)
                        begin
                            state_reg <= S_MUL;
                        end
                        else
                        begin
                            hash_reg  <= '0;
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_CRC:
                begin
                    hash_reg <= crc_next;
                    if (end_of_seg)
                    begin
                        byte_reg <= '0;
                        if (final_seg)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            seg_reg <= seg_t'(seg_reg + 3'd1);
                        end
                    end
                    else
                    begin
                        byte_reg <= byte_reg + 2'd1;
                    end
                end
                S_MUL:
                begin
                    hash_reg <= mac_next;
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == 2'd3)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!res_full)
                    begin
                        acc_reg   <= acc_next;
                        drop_reg  <= drop_next;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // The CRC sequencer never runs past the last address call.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CRC) |-> (seg_reg <= SEG_A2))
        else $error("crc segment out of range");

    // With sampling off the counters hold across a delivered result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && !cfg.sampling_on) |=> ($stable(acc_reg) && $stable(drop_reg)))
        else $error("counters moved with sampling off");

    // A new key is taken only when the previous result has left.
    assert property (@(posedge clk) disable iff (!rst_n)
        key_pop |-> !$past(state_reg == S_DONE && res_full))
        else $error("key taken while a result was stalled");
`endif

endmodule

>>> hw/rtl/symmetric_flow_hash_sampler.sv
// Top level of the symmetric flow hash sampler: configuration registers, key queue,
// front end, hash engine and result queue. Depends on sfh_pkg, sfh_front, sfh_fifo, sfh_engine.
//
// Usage: keys enter through a queue-like port (push/full); a key is transferred at a rising
// edge with push high and full low. Results leave through empty/pop: the oldest result is
// on the result ports while empty is low and is transferred on pop with empty low.
// Configuration is written through cfg_write/cfg_index/cfg_data. The user must write it
// only while idle; the block itself does not enforce this. Endpoints are ordered as the key
// enters; the hash engine then takes the key from a small queue and works on one key at a
// time. In the engine a key is loaded, then hashed, and then its result is posted. CRC mode
// takes one byte per cycle through the CRC unit (code bytes, then for IPv4 keys ports and
// addresses); multiplicative mode does one multiply-accumulate per cycle, and a non-IPv4
// key there gets a zero hash with no steps.
// Reset clears the queues, the counters and the registers to their defaults. When the
// receiver stalls, results collect in the result queue, then the engine holds its
// finished result, then keys fill the key queue and full rises.
module symmetric_flow_hash_sampler #(
    parameter int CODE_BYTES  = sfh_pkg::CODE_BYTES_DEFAULT,
    parameter int QUEUE_DEPTH = sfh_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [sfh_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                     cfg_data,
    input  logic                            push,
    output logic                            full,
    input  logic [31:0]                     source_address,
    input  logic [31:0]                     dest_address,
    input  logic [15:0]                     source_port,
    input  logic [15:0]                     dest_port,
    input  logic                            is_ipv4,
    input  logic [7:0]                      network_code,
    input  logic [7:0]                      transport_code,
    output logic                            empty,
    input  logic                            pop,
    output logic [31:0]                     hash_value,
    output logic                            accepted,
    output logic [31:0]                     accepted_total,
    output logic [31:0]                     dropped_total
);

    localparam int KEY_W = $bits(sfh_pkg::key_t);
    localparam int RES_W = $bits(sfh_pkg::result_t);

    sfh_pkg::cfg_t    cfg_reg;
    sfh_pkg::key_t    front_key;
    logic [KEY_W-1:0] key_head;
    logic             key_empty;
    logic             key_pop;
    logic             res_full;
    logic             res_push;
    sfh_pkg::result_t res_new;
    logic [RES_W-1:0] res_head_bits;
    sfh_pkg::result_t res_head;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.crc_polynomial <= '0;
            cfg_reg.sampling_on    <= 1'b0;
            cfg_reg.sampling_limit <= sfh_pkg::ALL_ONES;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                sfh_pkg::REG_CRC_POLYNOMIAL: cfg_reg.crc_polynomial <= cfg_data;
                sfh_pkg::REG_SAMPLING_ON:    cfg_reg.sampling_on    <= cfg_data[0];
                sfh_pkg::REG_SAMPLING_LIMIT: cfg_reg.sampling_limit <= cfg_data;
                default:                     cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // Front end: canonical endpoint order.
    sfh_front u_front (
        .source_address (source_address),
        .dest_address   (dest_address),
        .source_port    (source_port),
        .dest_port      (dest_port),
        .is_ipv4        (is_ipv4),
        .network_code   (network_code),
        .transport_code (transport_code),
        .key            (front_key)
    );

    // Queue between front end and hash engine.
    sfh_fifo #(
        .WIDTH (KEY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_key_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (push),
        .wdata (front_key),
        .rd_en (key_pop),
        .rdata (key_head),
        .full  (full),
        .empty (key_empty)
    );

    // Hash engine with sampling and counters.
    sfh_engine #(
        .CODE_BYTES (CODE_BYTES)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .key_valid (!key_empty),
        .key       (key_head),
        .key_pop   (key_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_new)
    );

    // Result queue toward the receiver.
    sfh_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (res_push),
        .wdata (res_new),
        .rd_en (pop),
        .rdata (res_head_bits),
        .full  (res_full),
        .empty (empty)
    );

    assign res_head       = res_head_bits;
    assign hash_value     = res_head.hash_value;
    assign accepted       = res_head.accepted;
    assign accepted_total = res_head.accepted_total;
    assign dropped_total  = res_head.dropped_total;

endmodule
